// ----- src/mffe_pkg.sv -----
// Shared types, command codes and constants for the masked flood-fill engine.
`timescale 1ns / 1ps

package mffe_pkg;

    // Default sizes
    localparam int QUEUE_DEPTH_DEF = 8192;
    localparam int MAX_WIDTH_DEF   = 512;
    localparam int MAX_HEIGHT_DEF  = 512;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 9;
    localparam int BOUND_W = 10;
    // Neighbor math width: one above the bound width, so that a step left
    // of column zero wraps to a value above any bound
    localparam int NB_W    = BOUND_W + 1;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [BOUND_W-1:0] IMAGE_SIZE_RST = BOUND_W'(512);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEED  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd3;

    // Neighbor offsets in visit order: right, down, left, up
    localparam int NUM_NBRS = 4;
    localparam logic signed [1:0] NBR_DR [NUM_NBRS] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] NBR_DC [NUM_NBRS] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } cmd_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               pixel_valid;
        logic               queue_empty;
        logic               overflow;
    } result_t;

    // Active image bounds from the register file
    typedef struct packed {
        logic [BOUND_W-1:0] eff_width;
        logic [BOUND_W-1:0] eff_height;
    } bounds_t;

endpackage

// ----- src/mffe_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module mffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mffe_cfg.sv -----
// APB register file for the image size, with clamping to the built grid.
`timescale 1ns / 1ps

module mffe_cfg import mffe_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output bounds_t           bounds
);

    logic [BOUND_W-1:0] width_reg;
    logic [BOUND_W-1:0] width_next;
    logic [BOUND_W-1:0] height_reg;
    logic [BOUND_W-1:0] height_next;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // Register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_next  = pwdata[BOUND_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[BOUND_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_SIZE_RST;
            height_reg <= IMAGE_SIZE_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Bounds in use: register value clamped to the grid size
    always_comb
    begin
        bounds.eff_width  = (int'(width_reg) < MAX_WIDTH) ? width_reg
                                                           : BOUND_W'(MAX_WIDTH);
        bounds.eff_height = (int'(height_reg) < MAX_HEIGHT) ? height_reg
                                                             : BOUND_W'(MAX_HEIGHT);
    end

endmodule

// ----- src/masked_flood_fill_engine.sv -----
// Top level: command sequencer over the pixel mask RAM and the coordinate queue RAM.
`timescale 1ns / 1ps

// Masked 4-connected flood-fill engine.
// Commands enter on cmd with start; a command is taken when start is high and
// busy is low. Each command gives one result on result, marked by a one-cycle
// done strobe; the receiver cannot stall, and result holds until the next result.
// Block, seed and step on an empty queue finish in the execute state. A step
// with a pixel queued does one queue read, then four neighbor mask reads
// overlapped with the previous neighbor's mask write and push. A clear
// sweeps the whole mask RAM, MAX_WIDTH' * MAX_HEIGHT' bits, where the primes
// are the sizes rounded up to powers of two; the mask RAM is swept one bit a
// cycle.
// A new command may be taken in the cycle its predecessor's result shows.
// After reset the same sweep runs (busy high, no result) before the first
// command is taken.
// The APB port sets image_width at 0x0 and image_height at 0x4; it is
// always ready and may be written only while busy is low and no result is
// pending.

module masked_flood_fill_engine import mffe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  cmd_in_t           cmd,
    output logic              done,
    output result_t           result
);

    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int MASK_AW    = RW + CW;
    localparam int MASK_DEPTH = 1 << MASK_AW;
    localparam int QAW        = $clog2(QUEUE_DEPTH);
    localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
    localparam int QDW        = RW + CW;

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_QWAIT = 3'd3;
    localparam logic [2:0] ST_NBR   = 3'd4;

    localparam logic [2:0] NB_LAST = 3'(NUM_NBRS);

    bounds_t bounds;

    logic [2:0]         state_reg,    state_next;
    cmd_in_t            cmd_reg,      cmd_next;
    logic [RW-1:0]      pr_reg,       pr_next;
    logic [CW-1:0]      pc_reg,       pc_next;
    logic [2:0]         nb_reg,       nb_next;
    logic [QAW-1:0]     head_reg,     head_next;
    logic [QAW-1:0]     tail_reg,     tail_next;
    logic [QCW-1:0]     count_reg,    count_next;
    logic               ovf_reg,      ovf_next;
    logic [MASK_AW-1:0] sweep_reg,    sweep_next;
    logic               clr_pend_reg, clr_pend_next;
    logic               done_reg,     done_next;
    result_t            result_reg,   result_next;

    // Memory ports
    logic               mask_we;
    logic [MASK_AW-1:0] mask_waddr;
    logic               mask_wdata;
    logic               mask_re;
    logic [MASK_AW-1:0] mask_raddr;
    logic               mask_rdata;
    logic               q_we;
    logic [QDW-1:0]     q_wdata;
    logic               q_re;
    logic [QDW-1:0]     q_rdata;

    // Sequencer helpers
    logic               accept;
    logic               in_ok;
    logic [MASK_AW-1:0] in_addr;
    logic [NB_W-1:0]    nb_row  [NUM_NBRS];
    logic [NB_W-1:0]    nb_col  [NUM_NBRS];
    logic               nb_ok   [NUM_NBRS];
    logic [MASK_AW-1:0] nb_addr [NUM_NBRS];
    logic [1:0]         rd_idx;
    logic [1:0]         dec_idx;
    logic               push_req;
    logic [QDW-1:0]     push_data;
    logic               finish;
    logic               finish_pix;

    mffe_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    // One usable bit per pixel, addressed {row, col}
    mffe_ram #(
        .WIDTH (1),
        .DEPTH (MASK_DEPTH),
        .AW    (MASK_AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    // Ring queue of {row, col}
    mffe_ram #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QAW)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign result  = result_reg;
    assign rd_idx  = nb_reg[1:0];
    assign dec_idx = 2'(nb_reg - 3'd1);

    // Bounds check and address for block and seed
    assign in_ok   = (NB_W'(cmd_reg.row) < NB_W'(bounds.eff_height))
                  && (NB_W'(cmd_reg.col) < NB_W'(bounds.eff_width));
    assign in_addr = {RW'(cmd_reg.row), CW'(cmd_reg.col)};

    // Neighbors of the popped pixel; a step off the low edge wraps high
    // and fails the bound compare
    always_comb
    begin
        for (int k = 0; k < NUM_NBRS; k++)
        begin
            nb_row[k]  = NB_W'(pr_reg) + NB_W'(NBR_DR[k]);
            nb_col[k]  = NB_W'(pc_reg) + NB_W'(NBR_DC[k]);
            nb_ok[k]   = (nb_row[k] < NB_W'(bounds.eff_height))
                      && (nb_col[k] < NB_W'(bounds.eff_width));
            nb_addr[k] = {RW'(nb_row[k]), CW'(nb_col[k])};
        end
    end

    // Sequencer. The four neighbors of one pixel are distinct entries, so a
    // mask read of neighbor k never meets the write of neighbor k-1.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pr_next       = pr_reg;
        pc_next       = pc_reg;
        nb_next       = nb_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        sweep_next    = sweep_reg;
        clr_pend_next = clr_pend_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        mask_we    = 1'b0;
        mask_waddr = in_addr;
        mask_wdata = 1'b0;
        mask_re    = 1'b0;
        mask_raddr = nb_addr[rd_idx];
        q_we       = 1'b0;
        q_re       = 1'b0;
        push_req   = 1'b0;
        push_data  = in_addr;
        finish     = 1'b0;
        finish_pix = 1'b0;

        case (state_reg)
            ST_SWEEP:
            begin
                mask_we    = 1'b1;
                mask_waddr = sweep_reg;
                mask_wdata = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                begin
                    state_next    = ST_IDLE;
                    clr_pend_next = 1'b0;
                    if (clr_pend_reg)
                    begin
                        done_next               = 1'b1;
                        result_next             = '0;
                        result_next.queue_empty = 1'b1;
                    end
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    if ((cmd.command == CMD_STEP) && (count_reg != '0))
                    begin
                        q_re       = 1'b1;
                        state_next = ST_QWAIT;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                case (cmd_reg.command)
                    CMD_CLEAR:
                    begin
                        head_next     = '0;
                        tail_next     = '0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        sweep_next    = '0;
                        clr_pend_next = 1'b1;
                        state_next    = ST_SWEEP;
                    end
                    CMD_BLOCK:
                    begin
                        mask_we = in_ok;
                        finish  = 1'b1;
                    end
                    CMD_SEED:
                    begin
                        mask_we  = in_ok;
                        push_req = in_ok;
                        finish   = 1'b1;
                    end
                    default:
                    begin
                        // step on an empty queue
                        finish = 1'b1;
                    end
                endcase
            end

            ST_QWAIT:
            begin
                pr_next    = q_rdata[QDW-1:CW];
                pc_next    = q_rdata[CW-1:0];
                head_next  = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                nb_next    = '0;
                state_next = ST_NBR;
            end

            ST_NBR:
            begin
                // read neighbor nb, decide neighbor nb-1
                mask_re = (nb_reg != NB_LAST);
                if ((nb_reg != '0) && nb_ok[dec_idx] && mask_rdata)
                begin
                    mask_we    = 1'b1;
                    mask_waddr = nb_addr[dec_idx];
                    push_req   = 1'b1;
                    push_data  = nb_addr[dec_idx];
                end
                if (nb_reg == NB_LAST)
                begin
                    finish     = 1'b1;
                    finish_pix = 1'b1;
                end
                else
                begin
                    nb_next = nb_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Queue push; a full queue drops it and flags overflow
        q_wdata = push_data;
        if (push_req)
        begin
            if (count_next == QCW'(QUEUE_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                q_we       = 1'b1;
                tail_next  = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_next = count_next + 1'b1;
            end
        end

        // Result for every command but clear
        if (finish)
        begin
            state_next              = ST_IDLE;
            done_next               = 1'b1;
            result_next.out_row     = finish_pix ? COORD_W'(pr_reg) : '0;
            result_next.out_col     = finish_pix ? COORD_W'(pc_reg) : '0;
            result_next.pixel_valid = finish_pix;
            result_next.queue_empty = (count_next == '0);
            result_next.overflow    = ovf_next;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            nb_reg       <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            sweep_reg    <= '0;
            clr_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            nb_reg       <= nb_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            sweep_reg    <= sweep_next;
            clr_pend_reg <= clr_pend_next;
            done_reg     <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pr_reg     <= pr_next;
        pc_reg     <= pc_next;
        result_reg <= result_next;
    end

endmodule
